// File: rtl/verlet_particle_step_unit_assert.svh
// Assertion macros shared by the particle step unit.
// Expects clk_i and rst_ni in the scope where they are used.
`ifndef VERLET_PARTICLE_STEP_UNIT_ASSERT_SVH
`define VERLET_PARTICLE_STEP_UNIT_ASSERT_SVH

// same-cycle implication
`define VPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vps assertion failed (same cycle)");

// next-cycle implication
`define VPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vps assertion failed (next cycle)");

`endif

// File: rtl/vps_pkg.sv
// Package for the particle step unit: widths, register indexes, record type
// and the saturate / truncating-shift helpers. No dependencies.
package vps_pkg;

  localparam int FRAC_BITS = 12;
  localparam int PASSES    = 4;

  localparam int POS_W   = 24;
  localparam int RAD_W   = 22;
  localparam int GRAV_W  = 18;
  localparam int EL_W    = 13;
  localparam int EL_FRAC = 12;
  localparam int MAXD_W  = RAD_W + 1;
  localparam int DIF_W   = POS_W + 1;
  localparam int SQ_W    = 2 * DIF_W;
  localparam int ROOT_W  = DIF_W;
  localparam int QW      = FRAC_BITS + 1;
  localparam int NRM_W   = QW + 1;
  localparam int PM_W    = NRM_W + MAXD_W;
  localparam int PV_W    = DIF_W + NRM_W;
  localparam int PS_W    = PV_W + 1;
  localparam int DOT_W   = DIF_W + 3;
  localparam int P2_W    = DOT_W + NRM_W + 1;
  localparam int VN_W    = DIF_W + 4;
  localparam int EP_W    = VN_W + EL_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = POS_W;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONT_RAD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ELASTICITY = 3'd4;

  localparam logic signed [POS_W-1:0]  RST_CENTER_X   = 24'sd1228800;
  localparam logic signed [POS_W-1:0]  RST_CENTER_Y   = 24'sd1228800;
  localparam logic [RAD_W-1:0]         RST_CONT_RAD   = 22'd1024000;
  localparam logic signed [GRAV_W-1:0] RST_GRAVITY    = 18'sd2048;
  localparam logic [EL_W-1:0]          RST_ELASTICITY = 13'd3686;

  localparam logic signed [63:0] POS_MAX = 64'sd8388607;
  localparam logic signed [63:0] POS_MIN = -64'sd8388608;

  // particle record travelling down the pipe, valid bit included
  typedef struct packed {
    logic                     vld;
    logic                     hit;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [POS_W-1:0]  ox;
    logic signed [POS_W-1:0]  oy;
    logic signed [MAXD_W-1:0] maxd;
  } rec_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [63:0] v);
    logic signed [POS_W-1:0] r;
    if (v > POS_MAX) r = POS_MAX[POS_W-1:0];
    else if (v < POS_MIN) r = POS_MIN[POS_W-1:0];
    else r = v[POS_W-1:0];
    return r;
  endfunction

  // divide by 2^sh rounding toward zero
  function automatic logic signed [63:0] tdiv_pow2(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic signed [63:0] bias;
    bias = (64'sd1 <<< sh) - 64'sd1;
    return (v < 0) ? ((v + bias) >>> sh) : (v >>> sh);
  endfunction

endpackage

// File: rtl/vps_if.sv
// Channel interfaces of the particle step unit: input item, result item and
// configuration write. Depends on vps_pkg.
interface vps_in_if import vps_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] prev_x;
  logic signed [POS_W-1:0] prev_y;
  logic [RAD_W-1:0]        ball_radius;
  modport source (output valid, pos_x, pos_y, prev_x, prev_y, ball_radius, input ready);
  modport sink   (input valid, pos_x, pos_y, prev_x, prev_y, ball_radius, output ready);
endinterface

interface vps_out_if import vps_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] new_x;
  logic signed [POS_W-1:0] new_y;
  logic signed [POS_W-1:0] new_prev_x;
  logic signed [POS_W-1:0] new_prev_y;
  logic                    hit_wall;
  modport source (output valid, new_x, new_y, new_prev_x, new_prev_y, hit_wall, input ready);
  modport sink   (input valid, new_x, new_y, new_prev_x, new_prev_y, hit_wall, output ready);
endinterface

interface vps_cfg_if import vps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/verlet_particle_step_unit.sv
// Particle step unit: one Verlet step with gravity, then PASSES circular-container
// constraint passes. One item enters per clock while the output is not stalled;
// each pass holds a 25-stage square root and 13-stage dividers. A stalled output
// freezes the whole pipe; the input stage still takes an item while it is empty.
// Configuration writes are taken at any time and should be made only while the
// pipe holds no item. Depends on vps_pkg, the channel interfaces and vps_pass.
module verlet_particle_step_unit import vps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  vps_in_if.sink           in_i,
  vps_out_if.source        out_o,
  vps_cfg_if.sink          cfg_i
);

  // configuration registers
  logic signed [POS_W-1:0]  cx_q, cy_q;
  logic [RAD_W-1:0]         cr_q;
  logic signed [GRAV_W-1:0] grav_q;
  logic [EL_W-1:0]          el_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= RST_CENTER_X;
      cy_q   <= RST_CENTER_Y;
      cr_q   <= RST_CONT_RAD;
      grav_q <= RST_GRAVITY;
      el_q   <= RST_ELASTICITY;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_CENTER_X:   cx_q   <= cfg_i.data[POS_W-1:0];
        REG_CENTER_Y:   cy_q   <= cfg_i.data[POS_W-1:0];
        REG_CONT_RAD:   cr_q   <= cfg_i.data[RAD_W-1:0];
        REG_GRAVITY:    grav_q <= cfg_i.data[GRAV_W-1:0];
        REG_ELASTICITY: el_q   <= cfg_i.data[EL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipe advance: output register free or being taken
  logic out_vld_q;
  logic en;
  logic in_acc;
  rec_t s0_q;
  rec_t s0_d;
  rec_t chain [PASSES+1];

  assign en          = !out_vld_q || out_o.ready;
  assign in_i.ready  = en || !s0_q.vld;
  assign in_acc      = in_i.valid && in_i.ready;

  // Verlet step
  always_comb begin
    s0_d      = '0;
    s0_d.vld  = in_i.valid;
    s0_d.hit  = 1'b0;
    s0_d.px   = sat_pos(64'(in_i.pos_x) + 64'(in_i.pos_x) - 64'(in_i.prev_x));
    s0_d.py   = sat_pos(64'(in_i.pos_y) + 64'(in_i.pos_y) - 64'(in_i.prev_y)
                        + 64'(grav_q));
    s0_d.ox   = in_i.pos_x;
    s0_d.oy   = in_i.pos_y;
    s0_d.maxd = $signed({1'b0, cr_q}) - $signed({1'b0, in_i.ball_radius});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
    end else if (in_i.ready) begin
      s0_q <= s0_d;
    end
  end

  assign chain[0] = s0_q;

  for (genvar p = 0; p < PASSES; p++) begin : g_pass
    vps_pass u_pass (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cx_i   (cx_q),
      .cy_i   (cy_q),
      .el_i   (el_q),
      .rec_i  (chain[p]),
      .rec_o  (chain[p+1])
    );
  end

  // output register
  rec_t last;
  rec_t out_q;

  assign last = chain[PASSES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= last;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.new_x      = out_q.px;
  assign out_o.new_y      = out_q.py;
  assign out_o.new_prev_x = out_q.ox;
  assign out_o.new_prev_y = out_q.oy;
  assign out_o.hit_wall   = out_q.hit;

  `include "verlet_particle_step_unit_assert.svh"

  `VPS_ASSERT_NXT(a_accept_lands, in_acc, s0_q.vld)
  `VPS_ASSERT_NXT(a_stall_holds_last, !en && last.vld, $stable(last))
  `VPS_ASSERT_NXT(a_last_reaches_out, en && last.vld, out_vld_q)
  `VPS_ASSERT_IMP(a_ready_when_empty, !s0_q.vld, in_i.ready)

endmodule

// File: rtl/vps_isqrt.sv
// Pipelined floor square root, one root bit per stage.
// Depends on vps_pkg.
module vps_isqrt import vps_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SQ_W-1:0]   rad_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [ROOT_W+1:0] rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SQ_W-1:0]   rad_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [ROOT_W+1:0] rem_in, rem_t, trial;
    logic [ROOT_W-1:0] root_in;
    logic [SQ_W-1:0]   rad_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    assign rem_t = {rem_in[ROOT_W-1:0], rad_in[SQ_W-1 -: 2]};
    assign trial = {root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_t >= trial) begin
          rem_q[k]  <= rem_t - trial;
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_t;
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
        rad_q[k] <= {rad_in[SQ_W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

// File: rtl/vps_div.sv
// Pipelined restoring divider: (mag << FRAC_BITS) / divisor, one quotient bit
// per stage. The quotient is known to fit QW bits. Depends on vps_pkg.
module vps_div import vps_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [DIF_W-1:0]  mag_i,
  input  logic [ROOT_W-1:0] divisor_i,
  output logic [QW-1:0]     quo_o
);

  localparam int DW = DIF_W + FRAC_BITS;
  localparam int RW = ROOT_W + 1;

  logic [DW-1:0] dividend;
  assign dividend = {mag_i, {FRAC_BITS{1'b0}}};

  logic [RW-1:0]     rem_q [QW];
  logic [QW-1:0]     lo_q  [QW];
  logic [QW-1:0]     quo_q [QW];
  logic [ROOT_W-1:0] div_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW-1:0]     rem_in, t;
    logic [QW-1:0]     lo_in, quo_in;
    logic [ROOT_W-1:0] div_in;

    if (k == 0) begin : g_first
      assign rem_in = RW'(dividend[DW-1:QW]);
      assign lo_in  = dividend[QW-1:0];
      assign quo_in = '0;
      assign div_in = divisor_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign quo_in = quo_q[k-1];
      assign div_in = div_q[k-1];
    end

    assign t = {rem_in[RW-2:0], lo_in[QW-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (t >= RW'(div_in)) begin
          rem_q[k] <= t - RW'(div_in);
          quo_q[k] <= {quo_in[QW-2:0], 1'b1};
        end else begin
          rem_q[k] <= t;
          quo_q[k] <= {quo_in[QW-2:0], 1'b0};
        end
        lo_q[k]  <= {lo_in[QW-2:0], 1'b0};
        div_q[k] <= div_in;
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// File: rtl/vps_pass.sv
// One circular-container constraint pass as a pipeline: distance, square root,
// normal by division, snap and velocity reflection. Depends on vps_pkg,
// vps_isqrt and vps_div.
module vps_pass import vps_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic signed [POS_W-1:0] cx_i,
  input  logic signed [POS_W-1:0] cy_i,
  input  logic [EL_W-1:0]         el_i,
  input  rec_t                    rec_i,
  output rec_t                    rec_o
);

  typedef struct packed {
    rec_t                    rec;
    logic signed [DIF_W-1:0] dx;
    logic signed [DIF_W-1:0] dy;
  } sq_side_t;

  typedef struct packed {
    rec_t rec;
    logic sx;
    logic sy;
    logic corr;
  } dv_side_t;

  // stage A: offset from centre
  rec_t                    a_rec_q;
  logic signed [DIF_W-1:0] a_dx_q, a_dy_q;
  // stage B: squares
  rec_t                    b_rec_q;
  logic signed [DIF_W-1:0] b_dx_q, b_dy_q;
  logic signed [SQ_W-1:0]  b_sqx_q, b_sqy_q;
  // stage C: sum of squares
  rec_t                    c_rec_q;
  logic signed [DIF_W-1:0] c_dx_q, c_dy_q;
  logic [SQ_W-1:0]         c_d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rec_q <= '0;
      b_rec_q <= '0;
      c_rec_q <= '0;
    end else if (en_i) begin
      a_rec_q <= rec_i;
      b_rec_q <= a_rec_q;
      c_rec_q <= b_rec_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_dx_q  <= DIF_W'(rec_i.px) - DIF_W'(cx_i);
      a_dy_q  <= DIF_W'(rec_i.py) - DIF_W'(cy_i);
      b_dx_q  <= a_dx_q;
      b_dy_q  <= a_dy_q;
      b_sqx_q <= SQ_W'(a_dx_q) * SQ_W'(a_dx_q);
      b_sqy_q <= SQ_W'(a_dy_q) * SQ_W'(a_dy_q);
      c_dx_q  <= b_dx_q;
      c_dy_q  <= b_dy_q;
      c_d2_q  <= unsigned'(b_sqx_q) + unsigned'(b_sqy_q);
    end
  end

  // square root with its side line
  logic [ROOT_W-1:0] sq_root;
  sq_side_t          sq_line_q [ROOT_W];

  vps_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  (c_d2_q),
    .root_o (sq_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROOT_W; i++) sq_line_q[i] <= '0;
    end else if (en_i) begin
      sq_line_q[0] <= '{rec: c_rec_q, dx: c_dx_q, dy: c_dy_q};
      for (int i = 1; i < ROOT_W; i++) sq_line_q[i] <= sq_line_q[i-1];
    end
  end

  // stage D: correction decision and magnitudes for the dividers
  sq_side_t          sq_out;
  logic              corr_d;
  rec_t              d_rec_q;
  logic              d_sx_q, d_sy_q, d_corr_q;
  logic [DIF_W-1:0]  d_mx_q, d_my_q;
  logic [ROOT_W-1:0] d_dist_q;

  assign sq_out = sq_line_q[ROOT_W-1];
  assign corr_d = (sq_root != '0) &&
                  ($signed({1'b0, sq_root}) > (ROOT_W+1)'(sq_out.rec.maxd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_rec_q <= '0;
    end else if (en_i) begin
      d_rec_q <= sq_out.rec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_sx_q   <= sq_out.dx[DIF_W-1];
      d_sy_q   <= sq_out.dy[DIF_W-1];
      d_corr_q <= corr_d;
      d_mx_q   <= sq_out.dx[DIF_W-1] ? unsigned'(-sq_out.dx) : unsigned'(sq_out.dx);
      d_my_q   <= sq_out.dy[DIF_W-1] ? unsigned'(-sq_out.dy) : unsigned'(sq_out.dy);
      d_dist_q <= sq_root;
    end
  end

  // normal components
  logic [QW-1:0] qx, qy;
  dv_side_t      dv_line_q [QW];

  vps_div u_div_x (
    .clk_i     (clk_i),
    .en_i      (en_i),
    .mag_i     (d_mx_q),
    .divisor_i (d_dist_q),
    .quo_o     (qx)
  );

  vps_div u_div_y (
    .clk_i     (clk_i),
    .en_i      (en_i),
    .mag_i     (d_my_q),
    .divisor_i (d_dist_q),
    .quo_o     (qy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QW; i++) dv_line_q[i] <= '0;
    end else if (en_i) begin
      dv_line_q[0] <= '{rec: d_rec_q, sx: d_sx_q, sy: d_sy_q, corr: d_corr_q};
      for (int i = 1; i < QW; i++) dv_line_q[i] <= dv_line_q[i-1];
    end
  end

  dv_side_t                dv_out;
  logic signed [NRM_W-1:0] nx_d, ny_d;

  assign dv_out = dv_line_q[QW-1];
  assign nx_d   = dv_out.sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign ny_d   = dv_out.sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

  // stages E to J: snap and reflection
  rec_t                    e_rec_q, f_rec_q, g_rec_q, h_rec_q, i_rec_q, j_rec_q;
  logic                    e_corr_q, f_corr_q, g_corr_q, h_corr_q, i_corr_q;
  logic signed [NRM_W-1:0] e_nx_q, e_ny_q, f_nx_q, f_ny_q;
  logic signed [DIF_W-1:0] e_vx_q, e_vy_q, f_vx_q, f_vy_q, g_vx_q, g_vy_q;
  logic signed [PM_W-1:0]  e_pmx_q, e_pmy_q;
  logic signed [PV_W-1:0]  e_pvx_q, e_pvy_q;
  logic signed [POS_W-1:0] f_spx_q, f_spy_q, g_spx_q, g_spy_q;
  logic signed [POS_W-1:0] h_spx_q, h_spy_q, i_spx_q, i_spy_q;
  logic signed [DOT_W-1:0] f_dot_q;
  logic signed [P2_W-1:0]  g_p2x_q, g_p2y_q;
  logic signed [VN_W-1:0]  h_vx_q, h_vy_q;
  logic signed [EP_W-1:0]  i_pex_q, i_pey_q;
  logic signed [PS_W-1:0]  dot_sum;
  logic signed [POS_W-1:0] fin_ox, fin_oy;
  rec_t                    j_d;

  assign dot_sum = PS_W'(e_pvx_q) + PS_W'(e_pvy_q);
  assign fin_ox  = sat_pos(64'(i_spx_q) - tdiv_pow2(64'(i_pex_q), EL_FRAC));
  assign fin_oy  = sat_pos(64'(i_spy_q) - tdiv_pow2(64'(i_pey_q), EL_FRAC));

  always_comb begin
    j_d = i_rec_q;
    if (i_corr_q) begin
      j_d.px  = i_spx_q;
      j_d.py  = i_spy_q;
      j_d.ox  = fin_ox;
      j_d.oy  = fin_oy;
      j_d.hit = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_rec_q <= '0;
      f_rec_q <= '0;
      g_rec_q <= '0;
      h_rec_q <= '0;
      i_rec_q <= '0;
      j_rec_q <= '0;
    end else if (en_i) begin
      e_rec_q <= dv_out.rec;
      f_rec_q <= e_rec_q;
      g_rec_q <= f_rec_q;
      h_rec_q <= g_rec_q;
      i_rec_q <= h_rec_q;
      j_rec_q <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // E: products with the normal
      e_corr_q <= dv_out.corr;
      e_nx_q   <= nx_d;
      e_ny_q   <= ny_d;
      e_vx_q   <= DIF_W'(dv_out.rec.px) - DIF_W'(dv_out.rec.ox);
      e_vy_q   <= DIF_W'(dv_out.rec.py) - DIF_W'(dv_out.rec.oy);
      e_pmx_q  <= PM_W'(nx_d) * PM_W'(dv_out.rec.maxd);
      e_pmy_q  <= PM_W'(ny_d) * PM_W'(dv_out.rec.maxd);
      e_pvx_q  <= PV_W'(DIF_W'(dv_out.rec.px) - DIF_W'(dv_out.rec.ox)) * PV_W'(nx_d);
      e_pvy_q  <= PV_W'(DIF_W'(dv_out.rec.py) - DIF_W'(dv_out.rec.oy)) * PV_W'(ny_d);
      // F: snapped position and dot product
      f_corr_q <= e_corr_q;
      f_nx_q   <= e_nx_q;
      f_ny_q   <= e_ny_q;
      f_vx_q   <= e_vx_q;
      f_vy_q   <= e_vy_q;
      f_spx_q  <= sat_pos(64'(cx_i) + tdiv_pow2(64'(e_pmx_q), FRAC_BITS));
      f_spy_q  <= sat_pos(64'(cy_i) + tdiv_pow2(64'(e_pmy_q), FRAC_BITS));
      f_dot_q  <= DOT_W'(tdiv_pow2(64'(dot_sum), FRAC_BITS));
      // G: 2 * dot * n
      g_corr_q <= f_corr_q;
      g_vx_q   <= f_vx_q;
      g_vy_q   <= f_vy_q;
      g_spx_q  <= f_spx_q;
      g_spy_q  <= f_spy_q;
      g_p2x_q  <= (P2_W'(f_dot_q) <<< 1) * P2_W'(f_nx_q);
      g_p2y_q  <= (P2_W'(f_dot_q) <<< 1) * P2_W'(f_ny_q);
      // H: reflected velocity
      h_corr_q <= g_corr_q;
      h_spx_q  <= g_spx_q;
      h_spy_q  <= g_spy_q;
      h_vx_q   <= VN_W'(g_vx_q) - VN_W'(tdiv_pow2(64'(g_p2x_q), FRAC_BITS));
      h_vy_q   <= VN_W'(g_vy_q) - VN_W'(tdiv_pow2(64'(g_p2y_q), FRAC_BITS));
      // I: elasticity
      i_corr_q <= h_corr_q;
      i_spx_q  <= h_spx_q;
      i_spy_q  <= h_spy_q;
      i_pex_q  <= EP_W'(h_vx_q) * EP_W'($signed({1'b0, el_i}));
      i_pey_q  <= EP_W'(h_vy_q) * EP_W'($signed({1'b0, el_i}));
    end
  end

  assign rec_o = j_rec_q;

endmodule
